[rtl/tt_pkg.sv]
// ----------------------------------------------------------------------------
// Task timer package
// Shared constants, codes and structs of the periodic/one-shot task timer.
// ----------------------------------------------------------------------------
package tt_pkg;

    localparam int PERIODIC_SLOTS = 16;
    localparam int ONESHOT_SLOTS  = 16;
    localparam int NUM_CELLS      = PERIODIC_SLOTS + ONESHOT_SLOTS;
    localparam int CNT_W          = $clog2(NUM_CELLS + 1);
    localparam int DIV_STEPS      = 32;
    localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_PERIOD  = 2'd1,
        OP_ONESHOT = 2'd2,
        OP_START   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_ACCEPT = 2'd0,
        KIND_REJECT = 2'd1,
        KIND_FIRE   = 2'd2,
        KIND_DONE   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    // entry travelling down the fire chain
    typedef struct packed {
        logic       pend;
        logic [7:0] id;
        logic       oneshot;
    } fire_t;

    // per-table control into the cells
    typedef struct packed {
        logic        tick_en;
        logic        load_en;
        logic        shift_en;
        logic [7:0]  load_id;
        logic [31:0] load_ticks;
    } cell_ctrl_t;

endpackage

[rtl/tt_divider.sv]
// ----------------------------------------------------------------------------
// Task timer divider
// Restoring divider, one quotient bit per cycle, 32-bit by 10-bit.
// ----------------------------------------------------------------------------
module tt_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [9:0]  divisor,
    output logic        done,
    output logic [31:0] quotient
);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [tt_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0]                 q_reg, q_next;
    logic [9:0]                  rem_reg, rem_next;
    logic [9:0]                  div_reg, div_next;
    logic [10:0]                 shifted;
    logic [10:0]                 diff;
    logic                        ge;

    // one restoring step
    always_comb
    begin
        shifted   = {rem_reg, q_reg[31]};
        diff      = shifted - {1'b0, div_reg};
        ge        = (shifted >= {1'b0, div_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = dividend;
            rem_next  = '0;
            // zero divisor behaves as one
            div_next  = (divisor == 10'd0) ? 10'd1 : divisor;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[30:0], ge};
            rem_next = ge ? diff[9:0] : shifted[9:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == tt_pkg::DIV_CNT_W'(tt_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

[rtl/tt_cell.sv]
// ----------------------------------------------------------------------------
// Task timer slot cell
// One task slot: counts ticks, takes a new task via the free-slot chain and
// passes fire entries to its neighbor toward the head of the chain.
// ----------------------------------------------------------------------------
module tt_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               is_oneshot,
    input  tt_pkg::cell_ctrl_t ctrl,
    input  logic               grant_in,
    output logic               grant_out,
    input  tt_pkg::fire_t      fire_in,
    output tt_pkg::fire_t      fire_out
);

    logic          used_reg, used_next;
    logic [7:0]    id_reg;
    logic [31:0]   ticks_reg;
    logic [31:0]   elapsed_reg, elapsed_next;
    tt_pkg::fire_t fire_reg, fire_next;
    logic [31:0]   inc;
    logic          due;
    logic          take;

    // lowest free slot wins: pass the grant on only past used slots
    assign grant_out = grant_in & used_reg;
    assign take      = ctrl.load_en & grant_in & ~used_reg;

    always_comb
    begin
        if (is_oneshot && elapsed_reg == 32'hFFFF_FFFF)
            inc = elapsed_reg;
        else
            inc = elapsed_reg + 32'd1;
        due = (inc >= ticks_reg);

        used_next    = used_reg;
        elapsed_next = elapsed_reg;
        fire_next    = fire_reg;
        if (take)
        begin
            used_next    = 1'b1;
            elapsed_next = '0;
        end
        if (ctrl.tick_en)
        begin
            fire_next.pend    = used_reg & due & (id_reg != 8'd0);
            fire_next.id      = id_reg;
            fire_next.oneshot = is_oneshot;
            if (used_reg)
            begin
                elapsed_next = due ? 32'd0 : inc;
                if (is_oneshot && due)
                    used_next = 1'b0;
            end
        end
        else if (ctrl.shift_en)
        begin
            fire_next = fire_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            fire_reg <= '0;
        end
        else
        begin
            used_reg <= used_next;
            fire_reg <= fire_next;
        end
    end

    always_ff @(posedge clk)
    begin
        elapsed_reg <= elapsed_next;
        if (take)
        begin
            id_reg    <= ctrl.load_id;
            ticks_reg <= ctrl.load_ticks;
        end
    end

    assign fire_out = fire_reg;

endmodule

[rtl/periodic_and_oneshot_task_timer.sv]
// ----------------------------------------------------------------------------
// Periodic and one-shot task timer
// Slot tables held in a chain of cells; ticks advance all slots at once and
// due tasks drain out through the fire chain, periodic slots first.
// ----------------------------------------------------------------------------
//  channel | signals                                        | flow
//  --------+------------------------------------------------+------------
//  in      | in_valid, in_stall, opcode/task_id/interval_ms | valid/stall
//  out     | out_valid, out_stall, kind/fired_id/...        | valid/stall
//  cfg     | cfg_valid, cfg_ready, cfg_data                 | valid/ready
//
//  Start: sets the running flag on accept, with no result beat. Tick before
//  start: accept, then the done beat. Tick: accept, one drain step per slot,
//  a step to leave the drain, then the done beat; steps wait while a fire
//  beat is stalled. Create: accept, the bit-serial divider steps, the slot
//  load as the divider finishes, then the result beat. One item at a time.
//  Reset clears control state; no clearing pass.
// ----------------------------------------------------------------------------
module periodic_and_oneshot_task_timer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [7:0]  task_id,
    input  logic [31:0] interval_ms,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  fired_id,
    output logic        from_oneshot,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [9:0]  cfg_data
);

    localparam int P = tt_pkg::PERIODIC_SLOTS;
    localparam int N = tt_pkg::NUM_CELLS;

    tt_pkg::state_t      state_reg, state_next;
    logic                running_reg;
    logic [9:0]          mpt_reg;
    logic [tt_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    tt_pkg::op_t         op_reg;
    logic [7:0]          id_reg;
    tt_pkg::kind_t       res_kind_reg, res_kind_next;
    logic [7:0]          res_id_reg, res_id_next;

    logic                out_valid_reg;
    tt_pkg::kind_t       kind_reg;
    logic [7:0]          fired_id_reg;
    logic                oneshot_reg;
    logic                last_reg;

    logic                in_acc;
    logic                out_free;
    logic                div_start;
    logic                div_done;
    logic [31:0]         quotient;
    logic [31:0]         ticks;
    logic                step;
    logic                emit_fire;
    logic                emit_res;
    logic                precheck_ok;
    logic                table_full;

    tt_pkg::cell_ctrl_t  ctrl_p, ctrl_o;
    logic [N-1:0]        grant_in, grant_out;
    tt_pkg::fire_t       fire_in  [N];
    tt_pkg::fire_t       fire_out [N];

    assign in_acc    = in_valid & ~in_stall;
    assign in_stall  = (state_reg != tt_pkg::ST_IDLE);
    assign out_free  = ~out_valid_reg | ~out_stall;
    assign cfg_ready = 1'b1;
    assign ticks     = (quotient == 32'd0) ? 32'd1 : quotient;

    assign precheck_ok = (opcode == tt_pkg::OP_PERIOD)
                         ? (task_id != 8'd0 && interval_ms != 32'd0) : running_reg;
    assign table_full  = (op_reg == tt_pkg::OP_PERIOD) ? grant_out[P-1] : grant_out[N-1];

    tt_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (interval_ms),
        .divisor  (mpt_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // slot chain: cell 0 is the head of the fire chain
    for (genvar g = 0; g < N; g++)
    begin : g_cell
        if (g == 0 || g == P)
        begin : g_first
            assign grant_in[g] = 1'b1;
        end
        else
        begin : g_next
            assign grant_in[g] = grant_out[g-1];
        end
        if (g == N - 1)
        begin : g_tail
            assign fire_in[g] = '0;
        end
        else
        begin : g_link
            assign fire_in[g] = fire_out[g+1];
        end
        tt_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .is_oneshot (g >= P),
            .ctrl       ((g >= P) ? ctrl_o : ctrl_p),
            .grant_in   (grant_in[g]),
            .grant_out  (grant_out[g]),
            .fire_in    (fire_in[g]),
            .fire_out   (fire_out[g])
        );
    end

    // next state
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        res_kind_next = res_kind_reg;
        res_id_next   = res_id_reg;
        case (state_reg)
            tt_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    res_id_next = task_id;
                    case (opcode)
                        tt_pkg::OP_TICK:
                        begin
                            res_kind_next = tt_pkg::KIND_DONE;
                            res_id_next   = 8'd0;
                            cnt_next      = '0;
                            state_next    = running_reg ? tt_pkg::ST_DRAIN
                                                        : tt_pkg::ST_EMIT;
                        end
                        tt_pkg::OP_PERIOD, tt_pkg::OP_ONESHOT:
                        begin
                            res_kind_next = tt_pkg::KIND_REJECT;
                            state_next    = precheck_ok ? tt_pkg::ST_DIV
                                                        : tt_pkg::ST_EMIT;
                        end
                        default:
                        begin
                            state_next = tt_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            tt_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    res_kind_next = table_full ? tt_pkg::KIND_REJECT
                                               : tt_pkg::KIND_ACCEPT;
                    state_next    = tt_pkg::ST_EMIT;
                end
            end
            tt_pkg::ST_DRAIN:
            begin
                if (cnt_reg == tt_pkg::CNT_W'(N))
                    state_next = tt_pkg::ST_EMIT;
                else if (step)
                    cnt_next = cnt_reg + 1'b1;
            end
            tt_pkg::ST_EMIT:
            begin
                if (out_free)
                    state_next = tt_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tt_pkg::ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        div_start = (state_reg == tt_pkg::ST_IDLE) && in_acc && precheck_ok
                    && (opcode == tt_pkg::OP_PERIOD || opcode == tt_pkg::OP_ONESHOT);
        step      = (state_reg == tt_pkg::ST_DRAIN) && (cnt_reg != tt_pkg::CNT_W'(N))
                    && (~fire_out[0].pend | out_free);
        emit_fire = step & fire_out[0].pend;
        emit_res  = (state_reg == tt_pkg::ST_EMIT) && out_free;

        ctrl_p.tick_en    = (state_reg == tt_pkg::ST_IDLE) && in_acc
                            && (opcode == tt_pkg::OP_TICK) && running_reg;
        ctrl_p.shift_en   = step;
        ctrl_p.load_id    = id_reg;
        ctrl_p.load_ticks = ticks;
        ctrl_p.load_en    = (state_reg == tt_pkg::ST_DIV) && div_done
                            && (op_reg == tt_pkg::OP_PERIOD);
        ctrl_o            = ctrl_p;
        ctrl_o.load_en    = (state_reg == tt_pkg::ST_DIV) && div_done
                            && (op_reg == tt_pkg::OP_ONESHOT);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tt_pkg::ST_IDLE;
            running_reg   <= 1'b0;
            mpt_reg       <= 10'd1;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_valid && cfg_ready)
                mpt_reg <= cfg_data;
            if (in_acc && opcode == tt_pkg::OP_START)
                running_reg <= 1'b1;
            if (emit_fire || emit_res)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        res_kind_reg <= res_kind_next;
        res_id_reg   <= res_id_next;
        if (in_acc)
        begin
            op_reg <= tt_pkg::op_t'(opcode);
            id_reg <= task_id;
        end
        if (emit_fire)
        begin
            kind_reg     <= tt_pkg::KIND_FIRE;
            fired_id_reg <= fire_out[0].id;
            oneshot_reg  <= fire_out[0].oneshot;
            last_reg     <= 1'b0;
        end
        else if (emit_res)
        begin
            kind_reg     <= res_kind_reg;
            fired_id_reg <= res_id_reg;
            oneshot_reg  <= 1'b0;
            last_reg     <= 1'b1;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign fired_id     = fired_id_reg;
    assign from_oneshot = oneshot_reg;
    assign last         = last_reg;

    // checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= tt_pkg::CNT_W'(N))
        else $error("drain count past chain length");

    a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == tt_pkg::ST_DIV)
        else $error("divider finished outside divide state");

    a_fire_id: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire |=> out_valid && kind == tt_pkg::KIND_FIRE && fired_id != 8'd0 && !last)
        else $error("fire beat with zero id or last set");

    a_single_emit: assert property (@(posedge clk) disable iff (!rst_n)
        !(emit_fire && emit_res))
        else $error("two result sources at once");

endmodule
